// ===== hdl/bup_pkg.sv =====
// ----------------------------------------------------------------------------
// bup_pkg: shared types and codes for the box UV projection block
// Operation, status, axis and mode codes, sequencer states and the default
// widths handed down to the channel interfaces and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package bup_pkg;

	// default widths
	localparam int COORD_BITS_DEF   = 24;
	localparam int UV_FRAC_BITS_DEF = 16;

	// operation codes (request field func)
	localparam logic [1:0] FUNC_CLEAR   = 2'd0;
	localparam logic [1:0] FUNC_ACCUM   = 2'd1;
	localparam logic [1:0] FUNC_PROJECT = 2'd2;

	// result status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_NONE  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	// axis codes
	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	// projection mode: per-face dominant axis
	localparam logic [1:0] MODE_BOX = 2'd3;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_ACCUM,
		ST_MUL,
		ST_SUM,
		ST_PICK,
		ST_SETUP,
		ST_DIV,
		ST_DONE
	} bup_state_t;

endpackage

`default_nettype wire

// ===== hdl/bup_if.sv =====
// ----------------------------------------------------------------------------
// bup_if: request and result channels of the box UV projection block
// Valid/ready channels; a transfer happens on a clock edge with both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface bup_in_if #(
	parameter int COORD_BITS = bup_pkg::COORD_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic [1:0]                   func;
	logic                         selected;
	logic signed [COORD_BITS-1:0] p0_x;
	logic signed [COORD_BITS-1:0] p0_y;
	logic signed [COORD_BITS-1:0] p0_z;
	logic signed [COORD_BITS-1:0] p1_x;
	logic signed [COORD_BITS-1:0] p1_y;
	logic signed [COORD_BITS-1:0] p1_z;
	logic signed [COORD_BITS-1:0] p2_x;
	logic signed [COORD_BITS-1:0] p2_y;
	logic signed [COORD_BITS-1:0] p2_z;

	modport source (
		output valid, func, selected,
		output p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
		input  ready
	);
	modport sink (
		input  valid, func, selected,
		input  p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
		output ready
	);
endinterface

interface bup_out_if #(
	parameter int UV_FRAC_BITS = bup_pkg::UV_FRAC_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic [UV_FRAC_BITS:0] u_first;
	logic [UV_FRAC_BITS:0] v_first;
	logic [UV_FRAC_BITS:0] u_second;
	logic [UV_FRAC_BITS:0] v_second;
	logic [UV_FRAC_BITS:0] u_third;
	logic [UV_FRAC_BITS:0] v_third;
	logic [1:0]            plane_axis;
	logic [1:0]            status;

	modport source (
		output valid, u_first, v_first, u_second, v_second, u_third, v_third,
		output plane_axis, status,
		input  ready
	);
	modport sink (
		input  valid, u_first, v_first, u_second, v_second, u_third, v_third,
		input  plane_axis, status,
		output ready
	);
endinterface

`default_nettype wire

// ===== hdl/box_uv_projection.sv =====
// ----------------------------------------------------------------------------
// box_uv_projection: planar and box UV projection of triangles
// Keeps a 3-D bounding box of selected triangles and projects triangles onto
// it, giving per-vertex UVs in unsigned Q1.UV_FRAC_BITS.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one triangle request (func, selected, nine coordinates);
//   out_ch returns exactly one result per request, in order.
//   cfg_wr_en/cfg_wr_data write projection_mode; write it only while idle.
// Steps per request, after decode:
//   clear, accumulate without selection, refused project: straight to done
//   accumulate with selection: one vertex per cycle into the box
//   planar project: the six UVs through the divider
//   box project: the face normal and its dominant axis first, then as planar
// A UV with zero extent or an offset at or below the minimum skips the
// divider. The six UV quotients share one restoring divider, one
// quotient bit per cycle; the normal uses one shared multiplier over six
// products. The next request is taken in the cycle after the previous result
// is loaded into the output register.
// Reset: bounds return to empty, mode to box, no result pending.
// A stalled receiver holds the result; the block can take one more request
// and finish it, then waits until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module box_uv_projection #(
	parameter int COORD_BITS   = bup_pkg::COORD_BITS_DEF,
	parameter int UV_FRAC_BITS = bup_pkg::UV_FRAC_BITS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wr_en,
	input  wire logic [1:0] cfg_wr_data,
	bup_in_if.sink          in_ch,
	bup_out_if.source       out_ch
);
	import bup_pkg::*;

	localparam int DW  = COORD_BITS + 1;        // edge vector width
	localparam int PW  = 2 * DW;                // product / normal width
	localparam int RW  = COORD_BITS + 1;        // offset, extent, remainder
	localparam int UVW = UV_FRAC_BITS + 1;      // UV width
	localparam int CW  = $clog2(UV_FRAC_BITS + 1);
	localparam logic [UVW-1:0] UV_ONE = UVW'(1) << UV_FRAC_BITS;
	localparam logic signed [COORD_BITS-1:0] COORD_HIGH = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam logic signed [COORD_BITS-1:0] COORD_LOW  = {1'b1, {(COORD_BITS-1){1'b0}}};

	// control state
	bup_state_t state_q, state_d;
	logic [1:0] mode_q;
	logic       seen_q;
	logic       out_valid_q;
	logic       in_ready;
	logic       out_load;
	logic       in_fire;

	// captured request
	logic [1:0]                   func_q;
	logic                         sel_q;
	logic signed [COORD_BITS-1:0] pv_q [3][3];

	// bounding box
	logic signed [COORD_BITS-1:0] bmin_q [3];
	logic signed [COORD_BITS-1:0] bmax_q [3];

	// sequencing
	logic [1:0] vcnt_q;
	logic [2:0] step_q;
	logic [2:0] uv_idx_q;
	logic [CW-1:0] cnt_q;
	logic [1:0] axis_q;
	logic [1:0] status_q;

	// normal datapath
	logic signed [DW-1:0] e_q [3];
	logic signed [DW-1:0] f_q [3];
	logic signed [DW-1:0] a_op, b_op;
	logic signed [PW-1:0] prod_d, mul_q, first_q;
	logic signed [PW:0]   ndiff_d;
	logic [PW-1:0]        nabs_d;
	logic [PW-1:0]        norm_q [3];
	logic [1:0]           pick_d;

	// divider datapath
	logic [1:0]                   ua, va, ax_sel, vert;
	logic signed [COORD_BITS-1:0] p_sel, lo_sel, hi_sel;
	logic [RW-1:0]                off_d, ext_d;
	logic                         zero_d, sat_d;
	logic [RW-1:0]                rem_q, ext_q, rem_sub;
	logic                         sat_q, ge_d;
	logic [UVW-1:0]               quo_q, quo_next, uv_res;
	logic [UVW-1:0]               uv_q [6];
	logic                         last_uv;

	// output register
	logic [UVW-1:0] u0_q, v0_q, u1_q, v1_q, u2_q, v2_q;
	logic [1:0]     oaxis_q, ostat_q;
	logic           ok;

	assign in_fire = in_ch.valid && in_ready;
	assign last_uv = (uv_idx_q == 3'd5);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				unique case (func_q)
					FUNC_CLEAR: state_d = ST_DONE;
					FUNC_ACCUM: state_d = sel_q ? ST_ACCUM : ST_DONE;
					FUNC_PROJECT: begin
						if (!sel_q || !seen_q) state_d = ST_DONE;
						else if (mode_q == MODE_BOX) state_d = ST_MUL;
						else state_d = ST_SETUP;
					end
					default: state_d = ST_DONE;
				endcase
			end
			ST_ACCUM: begin
				if (vcnt_q == 2'd2) state_d = ST_DONE;
			end
			ST_MUL: state_d = ST_SUM;
			ST_SUM: begin
				state_d = (step_q == 3'd5) ? ST_PICK : ST_MUL;
			end
			ST_PICK: state_d = ST_SETUP;
			ST_SETUP: begin
				if (!zero_d) state_d = ST_DIV;
				else if (last_uv) state_d = ST_DONE;
			end
			ST_DIV: begin
				if (cnt_q == '0) state_d = last_uv ? ST_DONE : ST_SETUP;
			end
			ST_DONE: begin
				if (out_load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		in_ready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_DONE: out_load = !out_valid_q || out_ch.ready;
			default: begin
				in_ready = 1'b0;
				out_load = 1'b0;
			end
		endcase
	end

	// control registers, mode and bounding box
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MODE_BOX;
			seen_q      <= 1'b0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < 3; k++) begin
				bmin_q[k] <= COORD_HIGH;
				bmax_q[k] <= COORD_LOW;
			end
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) mode_q <= cfg_wr_data;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
			if (state_q == ST_DECODE && func_q == FUNC_CLEAR) begin
				seen_q <= 1'b0;
				for (int k = 0; k < 3; k++) begin
					bmin_q[k] <= COORD_HIGH;
					bmax_q[k] <= COORD_LOW;
				end
			end
			// widen by one vertex per cycle
			if (state_q == ST_ACCUM) begin
				seen_q <= 1'b1;
				for (int k = 0; k < 3; k++) begin
					if (pv_q[vcnt_q][k] < bmin_q[k]) bmin_q[k] <= pv_q[vcnt_q][k];
					if (pv_q[vcnt_q][k] > bmax_q[k]) bmax_q[k] <= pv_q[vcnt_q][k];
				end
			end
		end
	end

	// shared multiplier operands: nx = e1f2-e2f1, ny = e2f0-e0f2, nz = e0f1-e1f0
	always_comb begin
		case (step_q)
			3'd0: begin a_op = e_q[1]; b_op = f_q[2]; end
			3'd1: begin a_op = e_q[2]; b_op = f_q[1]; end
			3'd2: begin a_op = e_q[2]; b_op = f_q[0]; end
			3'd3: begin a_op = e_q[0]; b_op = f_q[2]; end
			3'd4: begin a_op = e_q[0]; b_op = f_q[1]; end
			default: begin a_op = e_q[1]; b_op = f_q[0]; end
		endcase
	end

	assign prod_d  = $signed(PW'(a_op)) * $signed(PW'(b_op));
	assign ndiff_d = $signed((PW+1)'(first_q)) - $signed((PW+1)'(mul_q));
	assign nabs_d  = ndiff_d[PW] ? PW'(-ndiff_d) : PW'(ndiff_d);

	// dominant axis, ties to X then Y
	always_comb begin
		if (norm_q[0] >= norm_q[1] && norm_q[0] >= norm_q[2]) pick_d = AXIS_X;
		else if (norm_q[1] >= norm_q[2]) pick_d = AXIS_Y;
		else pick_d = AXIS_Z;
	end

	// operand select for the current UV
	assign ua     = (axis_q == AXIS_X) ? AXIS_Y : AXIS_X;
	assign va     = (axis_q == AXIS_Z) ? AXIS_Y : AXIS_Z;
	assign ax_sel = uv_idx_q[0] ? va : ua;
	assign vert   = uv_idx_q[2:1];
	assign p_sel  = pv_q[vert][ax_sel];
	assign lo_sel = bmin_q[ax_sel];
	assign hi_sel = bmax_q[ax_sel];
	assign off_d  = RW'(p_sel) - RW'(lo_sel);
	assign ext_d  = RW'(hi_sel) - RW'(lo_sel);
	assign zero_d = (hi_sel <= lo_sel) || (p_sel <= lo_sel);
	assign sat_d  = off_d >= {ext_d[RW-2:0], 1'b0};

	// one quotient bit per cycle
	assign ge_d     = rem_q >= ext_q;
	assign rem_sub  = ge_d ? rem_q - ext_q : rem_q;
	assign quo_next = {quo_q[UVW-2:0], ge_d};
	assign uv_res   = (sat_q || quo_next > UV_ONE) ? UV_ONE : quo_next;

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			func_q     <= in_ch.func;
			sel_q      <= in_ch.selected;
			pv_q[0][0] <= in_ch.p0_x;
			pv_q[0][1] <= in_ch.p0_y;
			pv_q[0][2] <= in_ch.p0_z;
			pv_q[1][0] <= in_ch.p1_x;
			pv_q[1][1] <= in_ch.p1_y;
			pv_q[1][2] <= in_ch.p1_z;
			pv_q[2][0] <= in_ch.p2_x;
			pv_q[2][1] <= in_ch.p2_y;
			pv_q[2][2] <= in_ch.p2_z;
		end

		unique case (state_q)
			ST_DECODE: begin
				vcnt_q   <= 2'd0;
				step_q   <= 3'd0;
				uv_idx_q <= 3'd0;
				axis_q   <= mode_q;
				if (func_q == FUNC_PROJECT && sel_q)
					status_q <= seen_q ? STAT_OK : STAT_EMPTY;
				else
					status_q <= STAT_NONE;
				for (int k = 0; k < 3; k++) begin
					e_q[k] <= DW'(pv_q[1][k]) - DW'(pv_q[0][k]);
					f_q[k] <= DW'(pv_q[2][k]) - DW'(pv_q[0][k]);
				end
			end
			ST_ACCUM: vcnt_q <= vcnt_q + 2'd1;
			ST_MUL: mul_q <= prod_d;
			ST_SUM: begin
				if (!step_q[0]) first_q <= mul_q;
				else norm_q[step_q[2:1]] <= nabs_d;
				step_q <= step_q + 3'd1;
			end
			ST_PICK: axis_q <= pick_d;
			ST_SETUP: begin
				rem_q <= off_d;
				ext_q <= ext_d;
				sat_q <= sat_d;
				quo_q <= '0;
				cnt_q <= CW'(UV_FRAC_BITS);
				if (zero_d) begin
					uv_q[uv_idx_q] <= '0;
					uv_idx_q       <= uv_idx_q + 3'd1;
				end
			end
			ST_DIV: begin
				rem_q <= {rem_sub[RW-2:0], 1'b0};
				quo_q <= quo_next;
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == '0) begin
					uv_q[uv_idx_q] <= uv_res;
					uv_idx_q       <= uv_idx_q + 3'd1;
				end
			end
			default: begin
			end
		endcase
	end

	// output register; refused or bookkeeping results carry zero UVs
	assign ok = (status_q == STAT_OK);

	always_ff @(posedge clk) begin
		if (out_load) begin
			u0_q    <= ok ? uv_q[0] : '0;
			v0_q    <= ok ? uv_q[1] : '0;
			u1_q    <= ok ? uv_q[2] : '0;
			v1_q    <= ok ? uv_q[3] : '0;
			u2_q    <= ok ? uv_q[4] : '0;
			v2_q    <= ok ? uv_q[5] : '0;
			oaxis_q <= ok ? axis_q : AXIS_X;
			ostat_q <= status_q;
		end
	end

	assign in_ch.ready       = in_ready;
	assign out_ch.valid      = out_valid_q;
	assign out_ch.u_first    = u0_q;
	assign out_ch.v_first    = v0_q;
	assign out_ch.u_second   = u1_q;
	assign out_ch.v_second   = v1_q;
	assign out_ch.u_third    = u2_q;
	assign out_ch.v_third    = v2_q;
	assign out_ch.plane_axis = oaxis_q;
	assign out_ch.status     = ostat_q;

	// a taken request always starts decoding next
	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q == ST_DECODE)
		else $error("accepted request did not enter decode");

	// a non-projected result carries zero UVs and axis
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && ostat_q != STAT_OK |->
			u0_q == '0 && v0_q == '0 && u1_q == '0 && v1_q == '0 &&
			u2_q == '0 && v2_q == '0 && oaxis_q == AXIS_X)
		else $error("non-projected result with nonzero payload");

	// projected UVs stay within 0..1
	a_uv_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && ostat_q == STAT_OK |->
			u0_q <= UV_ONE && v0_q <= UV_ONE && u1_q <= UV_ONE &&
			v1_q <= UV_ONE && u2_q <= UV_ONE && v2_q <= UV_ONE && oaxis_q != MODE_BOX)
		else $error("projected UV out of range");

	// a pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ch.ready |-> !out_load)
		else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

// ===== test/bup_uv_check.sv =====
// ----------------------------------------------------------------------------
// bup_uv_check: result checker for the box UV projection block
// Watches the config port and both channels, keeps its own copy of the
// bounding box and projection mode, works out the UVs that each accepted
// request must give, and compares every returned result in order.
// ----------------------------------------------------------------------------

module bup_uv_check #(
	parameter int CB = bup_pkg::COORD_BITS_DEF,
	parameter int FB = bup_pkg::UV_FRAC_BITS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wr_en,
	input  wire logic [1:0] cfg_wr_data,
	bup_in_if               in_ch,
	bup_out_if              out_ch,
	output int              fail_count,
	output int              pending
);
	import bup_pkg::*;

	localparam longint CMAX = (longint'(1) << (CB - 1)) - 1;
	localparam longint CMIN = -(longint'(1) << (CB - 1));
	localparam longint UV_ONE = longint'(1) << FB;

	typedef struct packed {
		logic [5:0][FB:0] uv;     // u0 v0 u1 v1 u2 v2
		logic [1:0]       axis;
		logic [1:0]       status;
	} uv_result_t;

	uv_result_t uv_expected_q[$];
	logic [1:0] mode = MODE_BOX;
	longint     box_min[3] = '{CMAX, CMAX, CMAX};
	longint     box_max[3] = '{CMIN, CMIN, CMIN};
	bit         box_seen = 1'b0;
	int         fails = 0;

	assign fail_count = fails;
	assign pending    = uv_expected_q.size();

	// dominant axis of the face normal; ties go to X, then Y
	function automatic logic [1:0] face_axis(input longint v[3][3]);
		longint e[3], f[3];
		longint nx, ny, nz;
		for (int k = 0; k < 3; k++) begin
			e[k] = v[1][k] - v[0][k];
			f[k] = v[2][k] - v[0][k];
		end
		nx = e[1] * f[2] - e[2] * f[1];
		ny = e[2] * f[0] - e[0] * f[2];
		nz = e[0] * f[1] - e[1] * f[0];
		if (nx < 0) nx = -nx;
		if (ny < 0) ny = -ny;
		if (nz < 0) nz = -nz;
		if (nx >= ny && nx >= nz)
			return AXIS_X;
		if (ny >= nz)
			return AXIS_Y;
		return AXIS_Z;
	endfunction

	// (p - min) / extent in Q1.FB, truncated and clamped to 0..1
	function automatic logic [FB:0] uv_coord(input longint p, input longint lo,
			input longint hi);
		longint q;
		if (hi <= lo || p <= lo)
			return '0;
		q = ((p - lo) << FB) / (hi - lo);
		if (q > UV_ONE)
			q = UV_ONE;
		return q[FB:0];
	endfunction

	function automatic string show(input uv_result_t r);
		return $sformatf("uv %0d %0d %0d %0d %0d %0d axis %0d status %0d",
			r.uv[0], r.uv[1], r.uv[2], r.uv[3], r.uv[4], r.uv[5], r.axis, r.status);
	endfunction

	// track state, predict on each request, compare on each result
	always @(posedge clk or negedge arst_n) begin : track
		uv_result_t want, got;
		longint     v[3][3];
		logic [1:0] axis;
		int         ua, va;
		if (!arst_n) begin
			mode     = MODE_BOX;
			box_min  = '{CMAX, CMAX, CMAX};
			box_max  = '{CMIN, CMIN, CMIN};
			box_seen = 1'b0;
			uv_expected_q.delete();
		end else begin
			// result side first: a result never belongs to a request taken on the same edge
			if (out_ch.valid && out_ch.ready) begin
				got.uv[0]  = out_ch.u_first;
				got.uv[1]  = out_ch.v_first;
				got.uv[2]  = out_ch.u_second;
				got.uv[3]  = out_ch.v_second;
				got.uv[4]  = out_ch.u_third;
				got.uv[5]  = out_ch.v_third;
				got.axis   = out_ch.plane_axis;
				got.status = out_ch.status;
				if (uv_expected_q.size() == 0) begin
					fails++;
					$display("%0t: result with no request pending: expected none, got %s",
						$time, show(got));
				end else begin
					want = uv_expected_q.pop_front();
					if (got !== want) begin
						fails++;
						$display("%0t: result mismatch: expected %s, got %s",
							$time, show(want), show(got));
					end
				end
			end

			if (cfg_wr_en)
				mode = cfg_wr_data;

			if (in_ch.valid && in_ch.ready) begin
				v[0][0] = in_ch.p0_x; v[0][1] = in_ch.p0_y; v[0][2] = in_ch.p0_z;
				v[1][0] = in_ch.p1_x; v[1][1] = in_ch.p1_y; v[1][2] = in_ch.p1_z;
				v[2][0] = in_ch.p2_x; v[2][1] = in_ch.p2_y; v[2][2] = in_ch.p2_z;
				want = '0;
				want.status = STAT_NONE;
				case (in_ch.func)
					FUNC_CLEAR: begin
						box_min  = '{CMAX, CMAX, CMAX};
						box_max  = '{CMIN, CMIN, CMIN};
						box_seen = 1'b0;
					end
					FUNC_ACCUM: begin
						if (in_ch.selected) begin
							for (int j = 0; j < 3; j++)
								for (int k = 0; k < 3; k++) begin
									if (v[j][k] < box_min[k]) box_min[k] = v[j][k];
									if (v[j][k] > box_max[k]) box_max[k] = v[j][k];
								end
							box_seen = 1'b1;
						end
					end
					FUNC_PROJECT: begin
						if (in_ch.selected && !box_seen) begin
							want.status = STAT_EMPTY;
						end else if (in_ch.selected) begin
							// planar modes map straight onto the axis codes
							axis = (mode == MODE_BOX) ? face_axis(v) : mode;
							ua = (axis == AXIS_X) ? 1 : 0;
							va = (axis == AXIS_Z) ? 1 : 2;
							for (int j = 0; j < 3; j++) begin
								want.uv[2 * j]     = uv_coord(v[j][ua], box_min[ua], box_max[ua]);
								want.uv[2 * j + 1] = uv_coord(v[j][va], box_min[va], box_max[va]);
							end
							want.axis   = axis;
							want.status = STAT_OK;
						end
					end
					default: ;  // unused code, ignored
				endcase
				uv_expected_q.push_back(want);
			end
		end
	end

endmodule

// ===== test/box_uv_projection_test.sv =====
// ----------------------------------------------------------------------------
// box_uv_projection_test: testbench top for the box UV projection block
// Drives triangle requests and mode writes: a directed pass over the edge
// cases, then random clear/accumulate/project sequences mixed with noise,
// under random sender bursts and receiver stalls. A side checker predicts
// and compares each result; this top gives the verdict.
// ----------------------------------------------------------------------------

module box_uv_projection_test;
	import bup_pkg::*;

	localparam int CB             = COORD_BITS_DEF;
	localparam int CMAX           = (1 << (CB - 1)) - 1;
	localparam int CMIN           = -(1 << (CB - 1));
	localparam int RANDOM_REQS    = 1200;
	localparam int LONG_HOLD      = 1500;
	localparam int WATCHDOG_LIMIT = 20000;

	// func code with no operation behind it
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [1:0] cfg_wr_data;
	int         fail_count;
	int         pending;
	bit         hold_req = 1'b0;
	bit         hold_done = 1'b0;
	int         burst_left = 0;

	bup_in_if  in_ch ();
	bup_out_if out_ch ();

	box_uv_projection dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_ch       (in_ch),
		.out_ch      (out_ch)
	);

	bup_uv_check uv_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_ch       (in_ch),
		.out_ch      (out_ch),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int clip_coord(input longint x);
		if (x > CMAX)
			return CMAX;
		if (x < CMIN)
			return CMIN;
		return int'(x);
	endfunction

	function automatic int any_coord();
		logic signed [CB-1:0] r;
		r = CB'($urandom);
		return int'(r);
	endfunction

	// three vertices scattered around a center, per-axis spread
	function automatic void cloud(output int c[9], input int ctr[3], input int sp[3]);
		for (int j = 0; j < 3; j++)
			for (int k = 0; k < 3; k++)
				c[3 * j + k] = clip_coord(longint'(ctr[k])
					+ longint'($urandom_range(0, 2 * sp[k])) - sp[k]);
	endfunction

	// offer one request, with a random gap at the start of each burst;
	// called and left at a falling edge
	task automatic send(input logic [1:0] func, input logic sel, input int c[9]);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
			if (gap != 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_ch.func     <= func;
		in_ch.selected <= sel;
		in_ch.p0_x <= c[0]; in_ch.p0_y <= c[1]; in_ch.p0_z <= c[2];
		in_ch.p1_x <= c[3]; in_ch.p1_y <= c[4]; in_ch.p1_z <= c[5];
		in_ch.p2_x <= c[6]; in_ch.p2_y <= c[7]; in_ch.p2_z <= c[8];
		in_ch.valid    <= 1'b1;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// stop offering and wait for every result to come back
	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		burst_left = 0;
	endtask

	task automatic set_mode(input logic [1:0] m);
		cfg_wr_data <= m;
		cfg_wr_en   <= 1'b1;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		@(negedge clk);
	endtask

	// clear, build a box from a few triangles, then project near it
	task automatic shaped_phase(inout int count);
		int ctr[3], sp[3], sp_out[3], c[9];
		int n_acc, n_proj;
		for (int k = 0; k < 3; k++) begin
			ctr[k] = any_coord();
			sp[k] = ($urandom_range(0, 9) == 0) ? 0 : (1 << $urandom_range(0, 22));
			sp_out[k] = sp[k] + sp[k] / 4 + (($urandom_range(0, 3) == 0) ? 16 : 0);
		end
		cloud(c, ctr, sp);
		send(FUNC_CLEAR, 1'($urandom_range(0, 1)), c);
		count++;
		n_acc = $urandom_range(1, 4);
		for (int i = 0; i < n_acc; i++) begin
			cloud(c, ctr, sp);
			send(FUNC_ACCUM, $urandom_range(0, 5) != 0, c);
			count++;
		end
		n_proj = $urandom_range(4, 24);
		for (int i = 0; i < n_proj; i++) begin
			if ($urandom_range(0, 3) == 0)
				cloud(c, ctr, sp_out);
			else
				cloud(c, ctr, sp);
			send(FUNC_PROJECT, $urandom_range(0, 7) != 0, c);
			count++;
		end
	endtask

	// any code, any flag, anywhere in the coordinate range
	task automatic noise_phase(inout int count);
		int c[9], n;
		logic [1:0] func;
		n = $urandom_range(4, 12);
		for (int i = 0; i < n; i++) begin
			for (int k = 0; k < 9; k++)
				c[k] = any_coord();
			func = 2'($urandom_range(0, 3));
			send(func, 1'($urandom_range(0, 1)), c);
			if (func != FUNC_UNUSED)
				count++;
		end
	endtask

	// receiver: random stall styles, each held for a random run, plus one long hold
	initial begin : receiver
		int left, style;
		left = 0;
		style = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				out_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				hold_done = 1'b1;
			end
			if (left == 0) begin
				style = $urandom_range(0, 3);
				left = $urandom_range(4, 80);
			end
			left--;
			case (style)
				0: out_ch.ready <= 1'b1;
				1: out_ch.ready <= 1'($urandom_range(0, 1));
				2: out_ch.ready <= ($urandom_range(0, 3) == 0);
				default: out_ch.ready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// watchdog on cycles with no transfer on either channel
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("box_uv_projection_test NOT OK");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int done_reqs;
		arst_n         = 1'b0;
		cfg_wr_en      = 1'b0;
		cfg_wr_data    = MODE_BOX;
		in_ch.valid    = 1'b0;
		in_ch.func     = FUNC_CLEAR;
		in_ch.selected = 1'b0;
		in_ch.p0_x = '0; in_ch.p0_y = '0; in_ch.p0_z = '0;
		in_ch.p1_x = '0; in_ch.p1_y = '0; in_ch.p1_z = '0;
		in_ch.p2_x = '0; in_ch.p2_y = '0; in_ch.p2_z = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty box: projection refused; ignored code; unselected requests
		send(FUNC_PROJECT, 1'b1, '{1, 2, 3, 4, 5, 6, 7, 8, 9});
		send(FUNC_UNUSED, 1'b1, '{CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, 0, -1, 1});
		send(FUNC_ACCUM, 1'b0, '{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0, 0, 0});
		send(FUNC_PROJECT, 1'b1, '{0, 0, 0, 1, 1, 1, 2, 2, 2});
		send(FUNC_PROJECT, 1'b0, '{0, 0, 0, 1, 1, 1, 2, 2, 2});
		// full-range box, box mode: corners, ties and a degenerate face
		send(FUNC_ACCUM, 1'b1, '{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0, 0, 0});
		send(FUNC_PROJECT, 1'b1, '{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0, CMAX, CMIN});
		send(FUNC_PROJECT, 1'b1, '{0, 0, 0, 1000, -1000, 0, 0, 1000, -1000});
		send(FUNC_PROJECT, 1'b1, '{0, 0, 0, 1000, 0, 0, 0, 1000, 1000});
		send(FUNC_PROJECT, 1'b1, '{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX});
		send(FUNC_PROJECT, 1'b1, '{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN});
		// flat box in X, points beyond the box on both sides
		send(FUNC_CLEAR, 1'b1, '{0, 0, 0, 0, 0, 0, 0, 0, 0});
		send(FUNC_ACCUM, 1'b1, '{100, -500, 0, 100, 500, 4096, 100, 0, 2048});
		send(FUNC_PROJECT, 1'b1, '{-9000, -9000, -9000, 9000, 9000, 9000, 100, 0, 1000});
		// each planar mode, then back to box
		for (int m = 0; m < 3; m++) begin
			wait_idle();
			set_mode(2'(m));
			send(FUNC_PROJECT, 1'b1, '{-9000, -9000, -9000, 9000, 9000, 9000, 100, 0, 1000});
			send(FUNC_PROJECT, 1'b1, '{100, -250, 1024, 0, 250, 3072, 200, 499, 4095});
		end
		wait_idle();
		set_mode(MODE_BOX);

		// random part
		done_reqs = 0;
		while (done_reqs < RANDOM_REQS) begin
			if ($urandom_range(0, 2) == 0) begin
				wait_idle();
				set_mode(2'($urandom_range(0, 3)));
			end
			if (!hold_req && done_reqs > RANDOM_REQS / 4)
				hold_req = 1'b1;
			if ($urandom_range(0, 4) == 0)
				noise_phase(done_reqs);
			else
				shaped_phase(done_reqs);
		end

		wait_idle();
		repeat (10) @(negedge clk);
		if (fail_count == 0)
			$display("box_uv_projection_test OK");
		else
			$display("box_uv_projection_test NOT OK");
		$finish;
	end

endmodule
